>>> hw/rtl/assert_macros.svh
// assertion macros shared by the list table engine rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define CLTE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define CLTE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/clte_pkg.sv
// types, codes and widths of the compact list table engine
// no dependencies
`timescale 1ns / 1ps

package clte_pkg;

	localparam int OP_W      = 3;
	localparam int VAL_W     = 32;
	localparam int POS_W     = 7;
	localparam int ST_W      = 3;
	localparam int IDX_W     = 7;
	localparam int CNT_OUT_W = 7;
	localparam int DEPTH_DEF = 64;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_READ   = 3'd1,
		OP_SEARCH = 3'd2,
		OP_UPDATE = 3'd3,
		OP_DELETE = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE     = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FOUND    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_INVALID  = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SEARCH,
		S_SHIFT
	} state_t;

	typedef enum logic [1:0] {
		RES_PLAIN,
		RES_WORD,
		RES_HIT
	} res_kind_t;

	typedef struct packed {
		logic      load;
		logic      append_wr;
		logic      update_wr;
		logic      shift_wr;
		logic      count_dec;
		logic      ptr_clr;
		logic      ptr_pos;
		logic      read_en;
		logic      emit;
		status_t   status;
		res_kind_t kind;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic cnt_zero;
		logic pos_ok;
		logic ptr_lt;
		logic valid_s1;
		logic hit_s1;
	} dp_stat_t;

endpackage

>>> hw/rtl/clte_ctrl.sv
// controller state machine of the compact list table engine
// depends on clte_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clte_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  clte_pkg::dp_stat_t   stat,
	output clte_pkg::ctrl_cmd_t  cmd
);

	clte_pkg::state_t state_q;
	clte_pkg::state_t state_d;
	logic             walk_done;

	assign walk_done = !stat.ptr_lt && !stat.valid_s1;
	assign busy      = (state_q != clte_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clte_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			clte_pkg::S_IDLE: begin
				if (start) begin
					state_d = clte_pkg::S_EXEC;
				end
			end
			clte_pkg::S_EXEC: begin
				case (stat.op)
					clte_pkg::OP_READ: begin
						state_d = stat.cnt_zero ? clte_pkg::S_IDLE : clte_pkg::S_READ;
					end
					clte_pkg::OP_SEARCH: begin
						state_d = clte_pkg::S_SEARCH;
					end
					clte_pkg::OP_DELETE: begin
						state_d = stat.pos_ok ? clte_pkg::S_SHIFT : clte_pkg::S_IDLE;
					end
					default: begin
						state_d = clte_pkg::S_IDLE;
					end
				endcase
			end
			clte_pkg::S_READ, clte_pkg::S_SHIFT: begin
				if (walk_done) begin
					state_d = clte_pkg::S_IDLE;
				end
			end
			clte_pkg::S_SEARCH: begin
				if (stat.hit_s1 || walk_done) begin
					state_d = clte_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = clte_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.status = clte_pkg::ST_DONE;
		cmd.kind   = clte_pkg::RES_PLAIN;
		case (state_q)
			clte_pkg::S_IDLE: begin
				cmd.load = start;
			end
			clte_pkg::S_EXEC: begin
				case (stat.op)
					clte_pkg::OP_APPEND: begin
						cmd.emit = 1'b1;
						if (stat.full) begin
							cmd.status = clte_pkg::ST_FULL;
						end else begin
							cmd.append_wr = 1'b1;
						end
					end
					clte_pkg::OP_READ: begin
						if (stat.cnt_zero) begin
							cmd.emit   = 1'b1;
							cmd.status = clte_pkg::ST_EMPTY;
						end else begin
							cmd.ptr_clr = 1'b1;
						end
					end
					clte_pkg::OP_SEARCH: begin
						cmd.ptr_clr = 1'b1;
					end
					clte_pkg::OP_UPDATE: begin
						cmd.emit = 1'b1;
						if (stat.pos_ok) begin
							cmd.update_wr = 1'b1;
						end else begin
							cmd.status = clte_pkg::ST_INVALID;
						end
					end
					clte_pkg::OP_DELETE: begin
						if (stat.pos_ok) begin
							cmd.ptr_pos = 1'b1;
						end else begin
							cmd.emit   = 1'b1;
							cmd.status = clte_pkg::ST_INVALID;
						end
					end
					default: begin
						cmd.emit   = 1'b1;
						cmd.status = clte_pkg::ST_INVALID;
					end
				endcase
			end
			clte_pkg::S_READ: begin
				cmd.read_en = stat.ptr_lt;
				cmd.emit    = stat.valid_s1;
				cmd.kind    = clte_pkg::RES_WORD;
			end
			clte_pkg::S_SEARCH: begin
				cmd.read_en = stat.ptr_lt && !stat.hit_s1;
				if (stat.hit_s1) begin
					cmd.emit   = 1'b1;
					cmd.status = clte_pkg::ST_FOUND;
					cmd.kind   = clte_pkg::RES_HIT;
				end else if (walk_done) begin
					cmd.emit   = 1'b1;
					cmd.status = clte_pkg::ST_NOTFOUND;
				end
			end
			clte_pkg::S_SHIFT: begin
				cmd.read_en  = stat.ptr_lt;
				cmd.shift_wr = stat.valid_s1;
				if (walk_done) begin
					cmd.count_dec = 1'b1;
					cmd.emit      = 1'b1;
				end
			end
			default: begin
				cmd.emit = 1'b0;
			end
		endcase
	end

	`CLTE_ASSERT(a_idle_no_read, (state_q != clte_pkg::S_IDLE) || !cmd.read_en, "read issued while idle")
	`CLTE_ASSERT_NEXT(a_single_ends, cmd.emit && (cmd.kind != clte_pkg::RES_WORD), state_q == clte_pkg::S_IDLE, "single result did not end the transaction")
	`CLTE_ASSERT(a_write_excl, !(cmd.shift_wr && (cmd.append_wr || cmd.update_wr)), "two writes at once")

endmodule

>>> hw/rtl/clte_datapath.sv
// datapath of the compact list table engine: word memory, count, walk pointer, results
// depends on clte_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clte_datapath #(
	parameter int DEPTH = clte_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  clte_pkg::ctrl_cmd_t                 cmd,
	output clte_pkg::dp_stat_t                  stat,
	input  logic [clte_pkg::OP_W-1:0]           operation,
	input  logic signed [clte_pkg::VAL_W-1:0]   value,
	input  logic [clte_pkg::POS_W-1:0]          position,
	output logic                                result_valid,
	output logic [clte_pkg::ST_W-1:0]           status,
	output logic signed [clte_pkg::VAL_W-1:0]   data,
	output logic [clte_pkg::IDX_W-1:0]          index,
	output logic [clte_pkg::CNT_OUT_W-1:0]      count,
	output logic                                last
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W = (CNT_W > clte_pkg::POS_W) ? CNT_W : clte_pkg::POS_W;

	logic [clte_pkg::VAL_W-1:0] mem [DEPTH];

	clte_pkg::op_t              op_q;
	logic [clte_pkg::VAL_W-1:0] value_q;
	logic [clte_pkg::POS_W-1:0] pos_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           ptr_q;

	logic                       valid_s1;
	logic [AW-1:0]              addr_s1;
	logic [clte_pkg::VAL_W-1:0] rdata_s1;

	logic                       res_valid_q;
	clte_pkg::status_t          status_q;
	logic [clte_pkg::VAL_W-1:0] data_q;
	logic [clte_pkg::IDX_W-1:0] index_q;
	logic                       last_q;

	logic [CMP_W-1:0]           pos_ext;
	logic [CMP_W-1:0]           count_ext;
	logic [CMP_W-1:0]           idx_ext;
	logic                       word_last;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [clte_pkg::VAL_W-1:0] wr_data;

	assign pos_ext   = CMP_W'(pos_q);
	assign count_ext = CMP_W'(count_q);
	assign idx_ext   = CMP_W'(addr_s1) + CMP_W'(1);
	assign word_last = (CNT_W'(addr_s1) + CNT_W'(1)) == count_q;

	assign stat.op       = op_q;
	assign stat.full     = (count_q == CNT_W'(DEPTH));
	assign stat.cnt_zero = (count_q == '0);
	assign stat.pos_ok   = (pos_ext != '0) && (pos_ext <= count_ext);
	assign stat.ptr_lt   = (ptr_q < count_q);
	assign stat.valid_s1 = valid_s1;
	assign stat.hit_s1   = valid_s1 && (rdata_s1 == value_q);

	// input fields of the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= clte_pkg::op_t'(operation);
			value_q <= value;
			pos_q   <= position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.append_wr) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.count_dec) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ptr_clr) begin
			ptr_q <= '0;
		end else if (cmd.ptr_pos) begin
			ptr_q <= CNT_W'(pos_ext);
		end else if (cmd.read_en) begin
			ptr_q <= ptr_q + CNT_W'(1);
		end
	end

	// write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = value_q;
		if (cmd.shift_wr) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1 - AW'(1);
			wr_data = rdata_s1;
		end else if (cmd.update_wr) begin
			wr_en   = 1'b1;
			wr_addr = AW'(pos_ext - CMP_W'(1));
		end else if (cmd.append_wr) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (cmd.read_en) begin
			rdata_s1 <= mem[ptr_q[AW-1:0]];
			addr_s1  <= ptr_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.read_en;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.status;
			case (cmd.kind)
				clte_pkg::RES_WORD: begin
					data_q  <= rdata_s1;
					index_q <= idx_ext[clte_pkg::IDX_W-1:0];
					last_q  <= word_last;
				end
				clte_pkg::RES_HIT: begin
					data_q  <= '0;
					index_q <= idx_ext[clte_pkg::IDX_W-1:0];
					last_q  <= 1'b1;
				end
				default: begin
					data_q  <= '0;
					index_q <= '0;
					last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign status       = status_q;
	assign data         = data_q;
	assign index        = index_q;
	assign last         = last_q;
	assign count        = count_ext[clte_pkg::CNT_OUT_W-1:0];

	`CLTE_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH), "word count above depth")
	`CLTE_ASSERT(a_read_in_list, !valid_s1 || (CNT_W'(addr_s1) < count_q), "read beyond stored words")
	`CLTE_ASSERT_NEXT(a_full_holds, cmd.emit && (cmd.status == clte_pkg::ST_FULL), $stable(count_q), "append when full changed the count")

endmodule

>>> hw/rtl/compact_list_table_engine.sv
// top level of the compact list table engine
// depends on clte_pkg, clte_ctrl and clte_datapath
`timescale 1ns / 1ps

// Keeps a packed list of up to DEPTH signed 32-bit words and a word count.
// Command channel: a transaction is taken at a clock edge with start high and
// busy low; operation, value and position are sampled there. busy stays high
// until the controller returns to idle, and one transaction runs at a time.
// Result channel: result_valid is high for one cycle per result with status,
// data, index, count and last; the receiver takes it in that cycle and has no
// way to hold it off. last marks the final result of a transaction.
// Append, update, invalid codes and reads of an empty list give a single
// result from the execute state. Read out issues one memory read a cycle
// and gives one word each cycle through the registered read port. Search
// walks one word a cycle through the registered memory read port and stops
// at the first hit or at the end of the list. Delete moves one word a cycle
// (read then write back one slot lower), then lowers the count.
// Reset clears the count, the controller and the result strobe; the word
// memory is not cleared, as only stored positions are ever read.
module compact_list_table_engine #(
	parameter int DEPTH = clte_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [clte_pkg::OP_W-1:0]           operation,
	input  logic signed [clte_pkg::VAL_W-1:0]   value,
	input  logic [clte_pkg::POS_W-1:0]          position,
	output logic                                result_valid,
	output logic [clte_pkg::ST_W-1:0]           status,
	output logic signed [clte_pkg::VAL_W-1:0]   data,
	output logic [clte_pkg::IDX_W-1:0]          index,
	output logic [clte_pkg::CNT_OUT_W-1:0]      count,
	output logic                                last
);

	clte_pkg::ctrl_cmd_t cmd;
	clte_pkg::dp_stat_t  stat;

	clte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	clte_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.operation    (operation),
		.value        (value),
		.position     (position),
		.result_valid (result_valid),
		.status       (status),
		.data         (data),
		.index        (index),
		.count        (count),
		.last         (last)
	);

endmodule

>>> verif/testbench.sv
// self-checking testbench for compact_list_table_engine
// depends on clte_pkg and the compact_list_table_engine rtl; a class-based list predictor
// checks every result strobe against the expected transaction output
`timescale 1ns / 1ps

module testbench;
	import clte_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 420;
	localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

	typedef struct packed {
		status_t                status;
		logic [VAL_W-1:0]       data;
		logic [IDX_W-1:0]       index;
		logic [CNT_OUT_W-1:0]   count;
		logic                   last;
	} list_result_t;

	typedef enum {PHASE_FILL, PHASE_MIX, PHASE_DRAIN} phase_t;

	class list_scoreboard;
		logic [VAL_W-1:0] words[LIST_DEPTH];
		int unsigned      n_words;
		list_result_t     pending[$];
		int unsigned      errors;

		function new();
			n_words = 0;
			errors = 0;
		endfunction

		function void push_result(status_t st, logic [VAL_W-1:0] d, int unsigned idx,
				logic lst);
			list_result_t r;
			r.status = st;
			r.data = d;
			r.index = IDX_W'(idx);
			r.count = CNT_OUT_W'(n_words);
			r.last = lst;
			pending.push_back(r);
		endfunction

		// list behavior for one accepted command
		function void note_command(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
				logic [POS_W-1:0] pos);
			int unsigned i;
			bit hit;
			hit = 0;
			case (op)
				OP_APPEND: begin
					if (n_words >= LIST_DEPTH) begin
						push_result(ST_FULL, '0, 0, 1'b1);
					end else begin
						words[n_words] = val;
						n_words++;
						push_result(ST_DONE, '0, 0, 1'b1);
					end
				end
				OP_READ: begin
					if (n_words == 0) begin
						push_result(ST_EMPTY, '0, 0, 1'b1);
					end else begin
						for (i = 0; i < n_words; i++)
							push_result(ST_DONE, words[i], i + 1, i + 1 == n_words);
					end
				end
				OP_SEARCH: begin
					for (i = 0; i < n_words && !hit; i++) begin
						if (words[i] == val) begin
							push_result(ST_FOUND, '0, i + 1, 1'b1);
							hit = 1;
						end
					end
					if (!hit)
						push_result(ST_NOTFOUND, '0, 0, 1'b1);
				end
				OP_UPDATE: begin
					if (pos >= 1 && pos <= n_words) begin
						words[pos - 1] = val;
						push_result(ST_DONE, '0, 0, 1'b1);
					end else begin
						push_result(ST_INVALID, '0, 0, 1'b1);
					end
				end
				OP_DELETE: begin
					if (pos >= 1 && pos <= n_words) begin
						for (i = pos - 1; i + 1 < n_words; i++)
							words[i] = words[i + 1];
						n_words--;
						push_result(ST_DONE, '0, 0, 1'b1);
					end else begin
						push_result(ST_INVALID, '0, 0, 1'b1);
					end
				end
				default: begin
					push_result(ST_INVALID, '0, 0, 1'b1);
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		task check_result(logic [ST_W-1:0] st, logic [VAL_W-1:0] d, logic [IDX_W-1:0] idx,
				logic [CNT_OUT_W-1:0] cnt, logic lst);
			list_result_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d data %0h", st, d));
			end else begin
				want = pending.pop_front();
				compare_field("status", VAL_W'(st), VAL_W'(want.status));
				compare_field("data", d, want.data);
				compare_field("index", VAL_W'(idx), VAL_W'(want.index));
				compare_field("count", VAL_W'(cnt), VAL_W'(want.count));
				compare_field("last", VAL_W'(lst), VAL_W'(want.last));
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [OP_W-1:0]        operation;
	logic [VAL_W-1:0]       value;
	logic [POS_W-1:0]       position;
	logic                   result_valid;
	logic [ST_W-1:0]        status;
	logic [VAL_W-1:0]       data;
	logic [IDX_W-1:0]       index;
	logic [CNT_OUT_W-1:0]   count;
	logic                   last;

	list_scoreboard sb;
	bit             no_idle;

	compact_list_table_engine u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.value        (value),
		.position     (position),
		.result_valid (result_valid),
		.status       (status),
		.data         (data),
		.index        (index),
		.count        (count),
		.last         (last)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(status, data, index, count, last);
	end

	// hold one transaction until the engine takes it
	task automatic issue(logic [OP_W-1:0] op, logic [VAL_W-1:0] val, logic [POS_W-1:0] pos);
		operation <= op;
		value <= val;
		position <= pos;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_command(op, val, pos);
	endtask

	task automatic idle_gap();
		int unsigned r;
		int unsigned len;
		r = $urandom_range(0, 15);
		if (no_idle || r < 9)
			len = 0;
		else if (r < 14)
			len = $urandom_range(1, 3);
		else
			len = $urandom_range(8, 40);
		if (len > 0) begin
			start <= 1'b0;
			value <= $urandom;
			position <= POS_W'($urandom);
			repeat (len) @(posedge clk);
		end
	endtask

	function automatic logic [VAL_W-1:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 3) begin
			case ($urandom_range(0, 7))
				0: return 32'h0000_0000;
				1: return 32'h0000_0001;
				2: return 32'hffff_ffff;
				3: return 32'h8000_0000;
				4: return 32'h7fff_ffff;
				5: return 32'h5a5a_5a5a;
				6: return 32'ha5a5_a5a5;
				default: return 32'h0001_0000;
			endcase
		end
		if (r < 6 && sb.n_words > 0)
			return sb.words[$urandom_range(0, sb.n_words - 1)];
		return $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_pos();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7 && sb.n_words > 0)
			return POS_W'($urandom_range(1, sb.n_words));
		if (r < 8)
			return '0;
		if (r < 9)
			return POS_W'(sb.n_words + 1);
		return POS_W'($urandom_range(0, 127));
	endfunction

	function automatic logic [OP_W-1:0] pick_op(phase_t ph);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (ph)
			PHASE_FILL: begin
				if (r < 85) return OP_APPEND;
				if (r < 89) return OP_READ;
				if (r < 94) return OP_SEARCH;
				if (r < 97) return OP_UPDATE;
				if (r < 98) return OP_DELETE;
			end
			PHASE_DRAIN: begin
				if (r < 65) return OP_DELETE;
				if (r < 72) return OP_APPEND;
				if (r < 78) return OP_READ;
				if (r < 88) return OP_SEARCH;
				if (r < 95) return OP_UPDATE;
			end
			default: begin
				if (r < 25) return OP_APPEND;
				if (r < 35) return OP_READ;
				if (r < 55) return OP_SEARCH;
				if (r < 75) return OP_UPDATE;
				if (r < 95) return OP_DELETE;
			end
		endcase
		return OP_RSVD_LO + OP_W'($urandom_range(0, OP_RSVD_HI - OP_RSVD_LO));
	endfunction

	task automatic directed_items();
		logic [OP_W-1:0] op;
		// empty list corner cases
		issue(OP_READ, 32'h1234_5678, 7'd0);
		issue(OP_SEARCH, 32'h0000_0000, 7'd0);
		issue(OP_UPDATE, 32'hdead_beef, 7'd1);
		issue(OP_DELETE, 32'h0, 7'd1);
		issue(OP_DELETE, 32'h0, 7'd0);
		// extremes of the word
		issue(OP_APPEND, 32'h8000_0000, 7'd127);
		issue(OP_APPEND, 32'h7fff_ffff, 7'd0);
		issue(OP_APPEND, 32'hffff_ffff, 7'd64);
		issue(OP_APPEND, 32'h0000_0000, 7'd1);
		issue(OP_APPEND, 32'h7fff_ffff, 7'd0);
		issue(OP_READ, 32'h0, 7'd0);
		// duplicate must report the first position
		issue(OP_SEARCH, 32'h7fff_ffff, 7'd0);
		issue(OP_SEARCH, 32'h1357_9bdf, 7'd0);
		issue(OP_UPDATE, 32'haaaa_5555, 7'd0);
		issue(OP_UPDATE, 32'h5555_aaaa, 7'd3);
		issue(OP_UPDATE, 32'h1, 7'd6);
		issue(OP_UPDATE, 32'h1, 7'd127);
		issue(OP_DELETE, 32'h0, 7'd1);
		issue(OP_DELETE, 32'h0, 7'd4);
		issue(OP_DELETE, 32'h0, 7'd127);
		for (op = OP_RSVD_LO; op != OP_RSVD_HI; op++)
			issue(op, 32'hffff_ffff, 7'd1);
		issue(OP_RSVD_HI, 32'hffff_ffff, 7'd1);
		issue(OP_READ, 32'h0, 7'd0);
		issue(OP_SEARCH, 32'h5555_aaaa, 7'd0);
	endtask

	task automatic random_items();
		int unsigned issued;
		int unsigned len;
		int unsigned k;
		int unsigned round;
		phase_t ph;
		logic [OP_W-1:0] op;
		issued = 0;
		round = 0;
		while (issued < RANDOM_ITEMS) begin
			case (round % 4)
				0: ph = PHASE_FILL;
				2: ph = PHASE_DRAIN;
				default: ph = PHASE_MIX;
			endcase
			round++;
			no_idle = ($urandom_range(0, 3) == 0);
			if (ph == PHASE_FILL)
				len = (LIST_DEPTH - sb.n_words) * 5 / 4 + 6;
			else if (ph == PHASE_DRAIN)
				len = sb.n_words + 6;
			else
				len = $urandom_range(20, 50);
			for (k = 0; k < len && issued < RANDOM_ITEMS; k++) begin
				op = pick_op(ph);
				issue(op, pick_word(), pick_pos());
				issued++;
				idle_gap();
			end
		end
		start <= 1'b0;
	endtask

	initial begin
		sb = new();
		no_idle = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_APPEND;
		value = '0;
		position = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		random_items();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.errors == 0)
			$display("compact_list_table_engine test passed");
		else
			$display("compact_list_table_engine test failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("compact_list_table_engine test failed");
		$finish;
	end

endmodule

>>> compact_list_table_engine.f
+incdir+hw/rtl
hw/rtl/clte_pkg.sv
hw/rtl/clte_ctrl.sv
hw/rtl/clte_datapath.sv
hw/rtl/compact_list_table_engine.sv
verif/testbench.sv
